// File: hdl/assert_macros.svh
// -----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands used by the RTL of this project (ocso_engine).
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/ocso_pkg.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ocso_pkg
// Types, constants and register indexes of the orbit camera offset block.
// -----------------------------------------------------------------------------
package ocso_pkg;

    localparam int ANGLE_BITS_DEF = 16;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_ROTATION_GAIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ZOOM_STEP     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_RADIUS    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RADIUS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PITCH_LIMIT   = 3'd4;

    localparam logic [15:0] RST_ROTATION_GAIN = 16'd26702;
    localparam logic [15:0] RST_ZOOM_STEP     = 16'd256;
    localparam logic [15:0] RST_MIN_RADIUS    = 16'd768;
    localparam logic [15:0] RST_MAX_RADIUS    = 16'd12800;
    localparam logic [13:0] RST_PITCH_LIMIT   = 14'd16167;

    localparam logic [13:0] RST_PITCH  = 14'd3129;
    localparam logic [15:0] RST_RADIUS = 16'd7680;

    // Stream widths.
    localparam int S_TDATA_W = 104;
    localparam int M_TDATA_W = 176;

    // Shared multiplier and polynomial sine in Q30.
    localparam int MUL_W  = 33;
    localparam int PROD_W = 2 * MUL_W;
    localparam logic [30:0] SIN_A    = 31'd1686629713;
    localparam logic [30:0] SIN_B    = 31'd688904866;
    localparam logic [30:0] SIN_C    = 31'd76016977;
    localparam logic [31:0] Q30_ONE  = 32'd1073741824;
    localparam int          TRIG_W   = 16;

    typedef struct packed {
        logic [15:0] rotation_gain;
        logic [15:0] zoom_step;
        logic [15:0] min_radius;
        logic [15:0] max_radius;
        logic [13:0] pitch_limit;
    } cfg_t;

    typedef struct packed {
        logic               rotate_held;
        logic signed [11:0] mouse_dx;
        logic signed [11:0] mouse_dy;
        logic signed [1:0]  wheel_dir;
        logic signed [23:0] target_x;
        logic signed [23:0] target_y;
        logic signed [23:0] target_z;
    } item_t;

    typedef struct packed {
        logic signed [23:0] cam_x;
        logic signed [23:0] cam_y;
        logic signed [23:0] cam_z;
        logic signed [17:0] offset_x;
        logic signed [17:0] offset_y;
        logic signed [17:0] offset_z;
        logic [15:0]        yaw_out;
        logic [13:0]        pitch_out;
        logic [15:0]        radius_out;
    } result_t;

    // Handshake between the stream wrapper and the engine.
    typedef struct packed {
        logic start;
        logic out_free;
    } ctl_t;

    typedef struct packed {
        logic idle;
        logic done;
    } stat_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DX,
        S_DY,
        S_PIT,
        S_ZZ,
        S_CZ,
        S_ZT,
        S_ZY,
        S_RND,
        S_OY,
        S_RC,
        S_OX,
        S_OZ,
        S_FIN,
        S_DONE
    } state_t;

endpackage

// File: hdl/ocso_engine.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// -----------------------------------------------------------------------------
// ocso_engine
// Sequencer around one shared multiplier: angle and radius update, four
// polynomial sine evaluations and the offset products of one request.
// -----------------------------------------------------------------------------
module ocso_engine #(
    parameter int ANGLE_BITS = ocso_pkg::ANGLE_BITS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  ocso_pkg::cfg_t    cfg,
    input  ocso_pkg::item_t   item,
    input  ocso_pkg::ctl_t    ctl,
    output ocso_pkg::stat_t   stat,
    output ocso_pkg::result_t result
);
    import ocso_pkg::*;

    localparam int Q  = ANGLE_BITS - 2;
    localparam int YW = (ANGLE_BITS > 16) ? ANGLE_BITS : 16;
    localparam int PW = (ANGLE_BITS > 14) ? ANGLE_BITS : 14;
    localparam int DW = (ANGLE_BITS > 20) ? ANGLE_BITS : 20;
    localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << Q;
    localparam logic [Q:0]            Q_ONE   = {1'b1, {Q{1'b0}}};

    state_t state_reg, state_next;
    logic [1:0] idx_reg, idx_next;

    logic [ANGLE_BITS-1:0] yaw_reg, yaw_next;
    logic [13:0]           pitch_reg, pitch_next;
    logic [15:0]           radius_reg, radius_next;

    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [MUL_W-1:0]  mul_a, mul_b;

    logic [30:0]              z_reg, z_next;
    logic [30:0]              z2_reg, z2_next;
    logic                     neg_reg, neg_next;
    logic signed [TRIG_W-1:0] trig_reg [4];
    logic signed [TRIG_W-1:0] trig_next [4];
    logic [MUL_W-1:0]         rc_reg, rc_next;
    logic signed [17:0]       ox_reg, ox_next;
    logic signed [17:0]       oy_reg, oy_next;
    logic signed [17:0]       oz_reg, oz_next;

    // Angle update terms.
    logic signed [19:0]    dmove;
    logic signed [DW-1:0]  dyaw_ext;
    logic signed [21:0]    psum;
    logic [13:0]           pitch_clamp;

    // Radius update terms.
    logic signed [17:0]    rsum;
    logic signed [17:0]    rlow;
    logic [15:0]           radius_upd;

    // Quarter-turn folding.
    logic [PW-1:0]         pitch_ext;
    logic [ANGLE_BITS-1:0] ang_base;
    logic [ANGLE_BITS-1:0] ang;
    logic [1:0]            quad;
    logic [Q:0]            fold_u;
    logic [30:0]           z_fold;

    // Polynomial and rounding terms.
    logic [30:0]              t_b;
    logic [30:0]              t_a;
    logic [31:0]              y_raw;
    logic [31:0]              y_sat;
    logic [31:0]              y_rnd;
    logic [14:0]              trig_mag;
    logic signed [TRIG_W-1:0] trig_val;
    logic signed [PROD_W-1:0] rnd14_sum;
    logic signed [PROD_W-1:0] rnd28_sum;
    logic [YW-1:0]            yaw_ext;

    function automatic logic [23:0] sat_add(input logic signed [23:0] t,
                                            input logic signed [17:0] o);
        logic signed [24:0] s;
        begin
            s = 25'(t) + 25'(o);
            if (s[24] != s[23]) begin
                sat_add = s[24] ? 24'h800000 : 24'h7FFFFF;
            end else begin
                sat_add = s[23:0];
            end
        end
    endfunction

    // Shared multiplier with a registered product.
    assign prod_next = mul_a * mul_b;

    // Both angle steps take bits [27:8] of the product, which is floor(v / 256).
    assign dmove    = prod_reg[27:8];
    assign dyaw_ext = DW'(dmove);
    assign psum     = $signed({8'b0, pitch_reg}) + 22'(dmove);

    always_comb begin
        if (psum[21]) begin
            pitch_clamp = '0;
        end else if (psum > $signed({8'b0, cfg.pitch_limit})) begin
            pitch_clamp = cfg.pitch_limit;
        end else begin
            pitch_clamp = psum[13:0];
        end
    end

    // Wheel code 1 zooms in; codes 2 and 3 both zoom out.
    always_comb begin
        if (item.wheel_dir == 2'sb01) begin
            rsum = $signed({2'b0, radius_reg}) - $signed({2'b0, cfg.zoom_step});
        end else begin
            rsum = $signed({2'b0, radius_reg}) + $signed({2'b0, cfg.zoom_step});
        end
        if (rsum < $signed({2'b0, cfg.min_radius})) begin
            rlow = $signed({2'b0, cfg.min_radius});
        end else begin
            rlow = rsum;
        end
        if (rlow > $signed({2'b0, cfg.max_radius})) begin
            radius_upd = cfg.max_radius;
        end else begin
            radius_upd = rlow[15:0];
        end
    end

    // Angle index 0 and 1 use pitch, 2 and 3 yaw; odd ones add a quarter turn.
    assign pitch_ext = PW'(pitch_reg);
    assign ang_base  = idx_reg[1] ? yaw_reg : pitch_ext[ANGLE_BITS-1:0];
    assign ang       = ang_base + (idx_reg[0] ? QUARTER : '0);
    assign quad      = ang[ANGLE_BITS-1:ANGLE_BITS-2];
    assign fold_u    = quad[0] ? (Q_ONE - {1'b0, ang[Q-1:0]}) : {1'b0, ang[Q-1:0]};
    assign z_fold    = 31'(fold_u) << (30 - Q);

    assign t_b      = SIN_B - prod_reg[60:30];
    assign t_a      = SIN_A - prod_reg[60:30];
    assign y_raw    = prod_reg[61:30];
    assign y_sat    = (y_raw > Q30_ONE) ? Q30_ONE : y_raw;
    assign y_rnd    = y_sat + 32'd32768;
    assign trig_mag = y_rnd[30:16];
    assign trig_val = neg_reg ? -$signed({1'b0, trig_mag}) : $signed({1'b0, trig_mag});

    assign rnd14_sum = prod_reg + (PROD_W'(1) << 13);
    assign rnd28_sum = prod_reg + (PROD_W'(1) << 27);

    always_comb begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        yaw_next    = yaw_reg;
        pitch_next  = pitch_reg;
        radius_next = radius_reg;
        z_next      = z_reg;
        z2_next     = z2_reg;
        neg_next    = neg_reg;
        trig_next   = trig_reg;
        rc_next     = rc_reg;
        ox_next     = ox_reg;
        oy_next     = oy_reg;
        oz_next     = oz_reg;
        mul_a       = '0;
        mul_b       = '0;
        case (state_reg)
            S_IDLE: begin
                if (ctl.start) begin
                    state_next = S_DX;
                end
            end
            S_DX: begin
                mul_a = MUL_W'(item.mouse_dx);
                mul_b = MUL_W'(cfg.rotation_gain);
                if (item.wheel_dir != 2'sb00) begin
                    radius_next = radius_upd;
                end
                state_next = S_DY;
            end
            S_DY: begin
                mul_a = MUL_W'(item.mouse_dy);
                mul_b = MUL_W'(cfg.rotation_gain);
                if (item.rotate_held) begin
                    yaw_next = yaw_reg + dyaw_ext[ANGLE_BITS-1:0];
                end
                state_next = S_PIT;
            end
            S_PIT: begin
                if (item.rotate_held) begin
                    pitch_next = pitch_clamp;
                end
                idx_next   = '0;
                state_next = S_ZZ;
            end
            S_ZZ: begin
                z_next     = z_fold;
                neg_next   = quad[1];
                mul_a      = MUL_W'(z_fold);
                mul_b      = MUL_W'(z_fold);
                state_next = S_CZ;
            end
            S_CZ: begin
                z2_next    = prod_reg[60:30];
                mul_a      = MUL_W'(SIN_C);
                mul_b      = MUL_W'(prod_reg[60:30]);
                state_next = S_ZT;
            end
            S_ZT: begin
                mul_a      = MUL_W'(z2_reg);
                mul_b      = MUL_W'(t_b);
                state_next = S_ZY;
            end
            S_ZY: begin
                mul_a      = MUL_W'(z_reg);
                mul_b      = MUL_W'(t_a);
                state_next = S_RND;
            end
            S_RND: begin
                trig_next[idx_reg] = trig_val;
                if (idx_reg == 2'd3) begin
                    state_next = S_OY;
                end else begin
                    idx_next   = idx_reg + 2'd1;
                    state_next = S_ZZ;
                end
            end
            S_OY: begin
                mul_a      = MUL_W'(radius_reg);
                mul_b      = MUL_W'(trig_reg[0]);
                state_next = S_RC;
            end
            S_RC: begin
                oy_next    = rnd14_sum[31:14];
                mul_a      = MUL_W'(radius_reg);
                mul_b      = MUL_W'(trig_reg[1]);
                state_next = S_OX;
            end
            S_OX: begin
                // r * cos(pitch) fits the operand width and feeds both horizontal terms.
                rc_next    = prod_reg[MUL_W-1:0];
                mul_a      = prod_reg[MUL_W-1:0];
                mul_b      = MUL_W'(trig_reg[2]);
                state_next = S_OZ;
            end
            S_OZ: begin
                ox_next    = rnd28_sum[45:28];
                mul_a      = rc_reg;
                mul_b      = MUL_W'(trig_reg[3]);
                state_next = S_FIN;
            end
            S_FIN: begin
                oz_next    = rnd28_sum[45:28];
                state_next = S_DONE;
            end
            S_DONE: begin
                if (ctl.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg    <= '0;
            yaw_reg    <= '0;
            pitch_reg  <= RST_PITCH;
            radius_reg <= RST_RADIUS;
        end else begin
            idx_reg    <= idx_next;
            yaw_reg    <= yaw_next;
            pitch_reg  <= pitch_next;
            radius_reg <= radius_next;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        z_reg    <= z_next;
        z2_reg   <= z2_next;
        neg_reg  <= neg_next;
        trig_reg <= trig_next;
        rc_reg   <= rc_next;
        ox_reg   <= ox_next;
        oy_reg   <= oy_next;
        oz_reg   <= oz_next;
    end

    assign yaw_ext = YW'(yaw_reg);

    always_comb begin
        result.cam_x      = sat_add(item.target_x, ox_reg);
        result.cam_y      = sat_add(item.target_y, oy_reg);
        result.cam_z      = sat_add(item.target_z, oz_reg);
        result.offset_x   = ox_reg;
        result.offset_y   = oy_reg;
        result.offset_z   = oz_reg;
        result.yaw_out    = yaw_ext[15:0];
        result.pitch_out  = pitch_reg;
        result.radius_out = radius_reg;
    end

    assign stat.idle = (state_reg == S_IDLE);
    assign stat.done = (state_reg == S_DONE);

    `ASSERT_IMPLY(a_start_idle, aclk, aresetn, ctl.start, state_reg == S_IDLE, "start while busy")
    `ASSERT_IMPLY(a_radius_cap, aclk, aresetn, (state_reg == S_DY) && (item.wheel_dir != 2'sb00), radius_reg <= cfg.max_radius, "radius above maximum after wheel step")
    `ASSERT_IMPLY(a_pitch_cap, aclk, aresetn, (state_reg == S_ZZ) && (idx_reg == 2'd0) && item.rotate_held, pitch_reg <= cfg.pitch_limit, "pitch above limit after rotate step")
    `ASSERT_IMPLY(a_trig_mag, aclk, aresetn, state_reg == S_RND, trig_mag <= 15'd16384, "sine magnitude above one")
    `ASSERT_NEXT(a_done_release, aclk, aresetn, (state_reg == S_DONE) && ctl.out_free, state_reg == S_IDLE, "result handed over but engine still busy")

endmodule

// File: hdl/orbit_camera_spherical_offset.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// orbit_camera_spherical_offset
// Orbit camera: updates yaw, pitch and radius per frame and returns the
// spherical offset and the camera position around the target.
// -----------------------------------------------------------------------------
// One request per frame goes in on the s_ side and one result comes out on the
// m_ side. From the acceptance of a request until its result is offered,
// s_tready stays low, so no new request is taken while one is in the engine:
// the single 33 by 33 bit multiplier forms 22 products in turn (two angle
// steps, four sine or cosine evaluations of four products each, four offset
// products), with a rounding step per sine and a few steps for the clamps and
// final sums. A finished result sits in the output register, so the next
// request is taken while it waits for m_tready.
// Configuration writes are meant for times when no request is in flight.
module orbit_camera_spherical_offset #(
    parameter int ANGLE_BITS = ocso_pkg::ANGLE_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Configuration
    input  logic                                cfg_we,
    input  logic [ocso_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [ocso_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // Request stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // rotate_held, mouse_dx, mouse_dy, wheel_dir, target_x, target_y, target_z
    input  logic [ocso_pkg::S_TDATA_W-1:0]      s_tdata,
    // Result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // cam_x, cam_y, cam_z, offset_x, offset_y, offset_z, yaw_out, pitch_out,
    // radius_out
    output logic [ocso_pkg::M_TDATA_W-1:0]      m_tdata
);
    import ocso_pkg::*;

    cfg_t    cfg_reg;
    item_t   item_reg;
    result_t out_reg;
    logic    m_valid_reg;

    ctl_t    ctl;
    stat_t   stat;
    result_t result;
    logic    out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.rotation_gain <= RST_ROTATION_GAIN;
            cfg_reg.zoom_step     <= RST_ZOOM_STEP;
            cfg_reg.min_radius    <= RST_MIN_RADIUS;
            cfg_reg.max_radius    <= RST_MAX_RADIUS;
            cfg_reg.pitch_limit   <= RST_PITCH_LIMIT;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_ROTATION_GAIN: cfg_reg.rotation_gain <= cfg_wdata;
                CFG_ZOOM_STEP:     cfg_reg.zoom_step     <= cfg_wdata;
                CFG_MIN_RADIUS:    cfg_reg.min_radius    <= cfg_wdata;
                CFG_MAX_RADIUS:    cfg_reg.max_radius    <= cfg_wdata;
                CFG_PITCH_LIMIT:   cfg_reg.pitch_limit   <= cfg_wdata[13:0];
                default: begin
                end
            endcase
        end
    end

    assign s_tready = stat.idle;
    assign out_free = !m_valid_reg || m_tready;

    assign ctl.start    = s_tvalid && s_tready;
    assign ctl.out_free = out_free;

    always_ff @(posedge aclk) begin
        if (ctl.start) begin
            item_reg.rotate_held <= s_tdata[0];
            item_reg.mouse_dx    <= s_tdata[12:1];
            item_reg.mouse_dy    <= s_tdata[24:13];
            item_reg.wheel_dir   <= s_tdata[26:25];
            item_reg.target_x    <= s_tdata[50:27];
            item_reg.target_y    <= s_tdata[74:51];
            item_reg.target_z    <= s_tdata[98:75];
        end
    end

    ocso_engine #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .item    (item_reg),
        .ctl     (ctl),
        .stat    (stat),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= stat.done;
        end
    end

    always_ff @(posedge aclk) begin
        if (stat.done && out_free) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0,
                       out_reg.radius_out,
                       out_reg.pitch_out,
                       out_reg.yaw_out,
                       out_reg.offset_z,
                       out_reg.offset_y,
                       out_reg.offset_x,
                       out_reg.cam_z,
                       out_reg.cam_y,
                       out_reg.cam_x};

endmodule
